[src/printf_number_formatter_unit_macros.svh]
// assertion macros for the printf number formatter
// used by the controller; no other dependencies
`ifndef PRINTF_NUMBER_FORMATTER_UNIT_MACROS_SVH
`define PRINTF_NUMBER_FORMATTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnf check failed");

// next-cycle implication, disabled during reset
`define PNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnf check failed");

`endif

[src/pnf_pkg.sv]
// shared types, codes and character helpers for the printf number formatter
// no dependencies
package pnf_pkg;

    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 64;
    localparam int CHAR_W    = 8;
    localparam int BUF_DEPTH = 18;
    localparam int BUF_IDX_W = $clog2(BUF_DEPTH);

    // conversion kinds
    localparam logic [CMD_W-1:0] K_CHAR = 3'd0;
    localparam logic [CMD_W-1:0] K_SDEC = 3'd1;
    localparam logic [CMD_W-1:0] K_UDEC = 3'd2;
    localparam logic [CMD_W-1:0] K_HEXL = 3'd3;
    localparam logic [CMD_W-1:0] K_HEXU = 3'd4;
    localparam logic [CMD_W-1:0] K_PTR  = 3'd5;

    // datapath operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DEC  = 3'd3;
    localparam logic [2:0] OP_HEX  = 3'd4;
    localparam logic [2:0] OP_PRE  = 3'd5;
    localparam logic [2:0] OP_POP  = 3'd6;

    // ceil(2^35 / 10), exact quotient for any 32-bit dividend
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] pre_idx;
    } pnf_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] kind;
        logic             neg;
        logic             vzero;
        logic             q_zero;
        logic             hex_done;
        logic             idx_zero;
    } pnf_stat_t;

    function automatic logic is_ptr(input logic [CMD_W-1:0] kind);
        return kind >= K_PTR;
    endfunction

    // number of characters ahead of the digits (or the whole text)
    function automatic logic [2:0] pre_len(input logic [CMD_W-1:0] kind,
                                           input logic neg, input logic vzero);
        logic [2:0] n;
        n = 3'd0;
        if (kind == K_CHAR)
            n = 3'd1;
        else if (kind == K_SDEC && neg)
            n = 3'd1;
        else if (is_ptr(kind))
            n = vzero ? 3'd5 : 3'd2;
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = 8'h30 + {4'b0000, d};
        else if (upper)
            c = 8'h37 + {4'b0000, d};
        else
            c = 8'h57 + {4'b0000, d};
        return c;
    endfunction

    // prefix characters, pushed last-to-first
    function automatic logic [CHAR_W-1:0] pfx_char(input logic [CMD_W-1:0] kind,
                                                   input logic vzero,
                                                   input logic [2:0] idx,
                                                   input logic [CHAR_W-1:0] low_byte);
        logic [CHAR_W-1:0] c;
        c = 8'h2D;
        if (kind == K_CHAR)
            c = low_byte;
        else if (is_ptr(kind))
        begin
            if (vzero)
            begin
                case (idx)
                    3'd0:    c = 8'h29;
                    3'd1:    c = 8'h6C;
                    3'd2:    c = 8'h69;
                    3'd3:    c = 8'h6E;
                    default: c = 8'h28;
                endcase
            end
            else
            begin
                c = (idx == 3'd0) ? 8'h78 : 8'h30;
            end
        end
        return c;
    endfunction

endpackage

[src/pnf_channels.sv]
// valid/ready channel interfaces for conversion requests and output characters
// depends on pnf_pkg
interface pnf_conv_if;
    logic                         valid;
    logic                         ready;
    logic [pnf_pkg::CMD_W-1:0]    command;
    logic [pnf_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface pnf_text_if;
    logic                         valid;
    logic                         ready;
    logic [pnf_pkg::CHAR_W-1:0]   out_char;
    logic                         last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

[src/pnf_datapath.sv]
// datapath: value register, divide-by-ten unit, hex digit slicer and character buffer
// depends on pnf_pkg
module pnf_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pnf_pkg::pnf_cmd_t           cmd,
    input  logic [pnf_pkg::CMD_W-1:0]   command,
    input  logic [pnf_pkg::VALUE_W-1:0] value,
    output pnf_pkg::pnf_stat_t          stat,
    output logic [pnf_pkg::CHAR_W-1:0]  out_char,
    output logic                        last
);
    import pnf_pkg::*;

    localparam int Q_W = 64 - RECIP_SH;

    logic [CMD_W-1:0]     kind_reg;
    logic                 neg_reg;
    logic                 vzero_reg;
    logic [VALUE_W-1:0]   work_reg;
    logic [63:0]          prod_reg;
    logic [CHAR_W-1:0]    buf_reg [BUF_DEPTH];
    logic [BUF_IDX_W-1:0] len_reg;
    logic [BUF_IDX_W-1:0] idx_reg;

    logic [Q_W-1:0]       quot;
    logic [31:0]          quot10;
    logic [31:0]          rem32;
    logic [CHAR_W-1:0]    push_char;
    logic                 push;
    logic [31:0]          low32;
    logic [VALUE_W-1:0]   load_val;

    assign quot   = prod_reg[63:RECIP_SH];
    assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem32  = work_reg[31:0] - quot10;
    assign low32  = value[31:0];

    always_comb
    begin
        if (command == K_CHAR || is_ptr(command))
            load_val = value;
        else if (command == K_SDEC && low32[31])
            load_val = {32'd0, 32'd0 - low32};
        else
            load_val = {32'd0, low32};
    end

    always_comb
    begin
        push      = 1'b0;
        push_char = pfx_char(kind_reg, vzero_reg, cmd.pre_idx, work_reg[CHAR_W-1:0]);
        case (cmd.op)
            OP_DEC:
            begin
                push      = 1'b1;
                push_char = 8'h30 + {4'b0000, rem32[3:0]};
            end
            OP_HEX:
            begin
                push      = 1'b1;
                push_char = hex_char(work_reg[3:0], kind_reg == K_HEXU);
            end
            OP_PRE:
            begin
                push = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg  <= command;
                neg_reg   <= low32[31];
                vzero_reg <= (value == '0);
                work_reg  <= load_val;
            end
            OP_MUL:
            begin
                prod_reg <= 64'(work_reg[31:0]) * 64'(RECIP10);
            end
            OP_DEC:
            begin
                work_reg <= {{(VALUE_W-Q_W){1'b0}}, quot};
            end
            OP_HEX:
            begin
                work_reg <= {4'b0000, work_reg[VALUE_W-1:4]};
            end
            default:
            begin
                work_reg <= work_reg;
            end
        endcase
        if (push)
            buf_reg[len_reg] <= push_char;
    end

    // buffer fill and read pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            len_reg <= '0;
            idx_reg <= '0;
        end
        else if (push)
        begin
            len_reg <= len_reg + 1'b1;
            idx_reg <= len_reg;
        end
        else if (cmd.op == OP_POP)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.neg      = neg_reg;
    assign stat.vzero    = vzero_reg;
    assign stat.q_zero   = (quot == '0);
    assign stat.hex_done = (work_reg[VALUE_W-1:4] == '0);
    assign stat.idx_zero = (idx_reg == '0);

    assign out_char = buf_reg[idx_reg];
    assign last     = (idx_reg == '0);

endmodule

[src/pnf_ctrl.sv]
// controller state machine: sequences load, digit generation, prefix and character output
// depends on pnf_pkg and printf_number_formatter_unit_macros.svh
`include "printf_number_formatter_unit_macros.svh"

module pnf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pnf_pkg::pnf_stat_t stat,
    output pnf_pkg::pnf_cmd_t  cmd
);
    import pnf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_HEX   = 3'd4;
    localparam logic [2:0] S_PRE   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [2:0] plen;

    assign plen      = pre_len(stat.kind, stat.neg, stat.vzero);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.op      = OP_NOP;
        cmd.pre_idx = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cnt_next = 3'd0;
                if (stat.kind == K_CHAR || (is_ptr(stat.kind) && stat.vzero))
                    state_next = S_PRE;
                else if (stat.kind inside {K_SDEC, K_UDEC})
                    state_next = S_MUL;
                else
                    state_next = S_HEX;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.op = OP_DEC;
                if (!stat.q_zero)
                    state_next = S_MUL;
                else if (plen == 3'd0)
                    state_next = S_EMIT;
                else
                    state_next = S_PRE;
            end
            S_HEX:
            begin
                cmd.op = OP_HEX;
                if (!stat.hex_done)
                    state_next = S_HEX;
                else if (plen == 3'd0)
                    state_next = S_EMIT;
                else
                    state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.op = OP_PRE;
                if (cnt_reg == plen - 3'd1)
                    state_next = S_EMIT;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.op = OP_POP;
                    if (stat.idx_zero)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `PNF_ASSERT_NEXT(a_accept_start, clk, rst_n, in_valid && in_ready, state_reg == S_START)
    `PNF_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && stat.idx_zero, state_reg == S_IDLE)
    `PNF_ASSERT_NOW(a_pre_bound, clk, rst_n, state_reg == S_PRE, cnt_reg < plen)
    `PNF_ASSERT_NOW(a_one_side, clk, rst_n, in_ready, !out_valid)

endmodule

[src/printf_number_formatter_unit.sv]
// printf number formatter top level: one conversion request in, ASCII characters out
// depends on pnf_pkg, pnf_channels, pnf_datapath and pnf_ctrl
//
// conv takes one request (command, value) when valid and ready are high; ready is
// high only while the unit is idle, so one request is worked on at a time.
// text gives the characters of that request in order, one per accepted beat, with
// last high on the final one. a stall on text simply holds the current character.
// per request: accept, decode the kind, then any digit phase, then any prefix
// characters, then the output characters, one per beat while text is ready.
// each decimal digit takes a 32x32 reciprocal multiply, then the remainder; each
// hex digit is sliced from the value; digits go into an 18-entry character buffer
// that is read back in reverse. only the decimal kinds use the divide-by-ten unit.
// reset returns the controller to idle and empties the buffer.
module printf_number_formatter_unit (
    input  logic  clk,
    input  logic  rst_n,
    pnf_conv_if.sink   conv,
    pnf_text_if.source text
);
    import pnf_pkg::*;

    pnf_cmd_t  cmd;
    pnf_stat_t stat;

    pnf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv.valid),
        .in_ready  (conv.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pnf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .command  (conv.command),
        .value    (conv.value),
        .stat     (stat),
        .out_char (text.out_char),
        .last     (text.last)
    );

endmodule

[test/printf_number_formatter_unit_tb.sv]
// testbench for printf_number_formatter_unit: directed and random conversion requests,
// with a built-in text predictor checking every output character and its last flag
// depends on pnf_pkg, pnf_channels and the formatter rtl
module printf_number_formatter_unit_tb;
    import pnf_pkg::*;

    // undefined command codes, formatted like a pointer
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam logic [CHAR_W-1:0] CH_ZERO    = "0";
    localparam logic [CHAR_W-1:0] CH_LOWER_A = "a";
    localparam logic [CHAR_W-1:0] CH_UPPER_A = "A";
    localparam logic [CHAR_W-1:0] CH_MINUS   = "-";
    localparam logic [CHAR_W-1:0] CH_X       = "x";
    localparam logic [39:0]       NIL_TEXT   = "(nil)";

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PER_PHASE = 76;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    logic clk;
    logic rst_n;

    pnf_conv_if conv_bus ();
    pnf_text_if text_bus ();

    text_beat_t text_expected[$];
    int         err_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         cycle_count;

    printf_number_formatter_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .conv  (conv_bus),
        .text  (text_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 10)
            c = CH_ZERO + d[CHAR_W-1:0];
        else if (upper)
            c = CH_UPPER_A + d[CHAR_W-1:0] - 8'd10;
        else
            c = CH_LOWER_A + d[CHAR_W-1:0] - 8'd10;
        return c;
    endfunction

    // works out the characters of one conversion and queues them
    task automatic predict_conversion(input logic [CMD_W-1:0] cmd,
                                      input logic [VALUE_W-1:0] val);
        logic [CHAR_W-1:0] chars[$];
        logic [CHAR_W-1:0] digits[$];
        logic [VALUE_W-1:0] mag;
        logic [31:0]        neg32;
        int unsigned        radix;
        logic               upper;
        logic               has_digits;
        text_beat_t         beat;
        has_digits = 1'b1;
        upper = 1'b0;
        radix = 10;
        mag = {32'd0, val[31:0]};
        case (cmd)
            K_CHAR:
            begin
                chars.push_back(val[7:0]);
                has_digits = 1'b0;
            end
            K_SDEC:
            begin
                if (val[31])
                begin
                    chars.push_back(CH_MINUS);
                    neg32 = 32'd0 - val[31:0];
                    mag = {32'd0, neg32};
                end
            end
            K_UDEC:
            begin
                radix = 10;
            end
            K_HEXL:
            begin
                radix = 16;
            end
            K_HEXU:
            begin
                radix = 16;
                upper = 1'b1;
            end
            default:
            begin
                if (val == '0)
                begin
                    for (int i = 4; i >= 0; i--)
                        chars.push_back(NIL_TEXT[i*8 +: 8]);
                    has_digits = 1'b0;
                end
                else
                begin
                    chars.push_back(CH_ZERO);
                    chars.push_back(CH_X);
                    mag = val;
                    radix = 16;
                end
            end
        endcase
        if (has_digits)
        begin
            do
            begin
                digits.push_front(digit_char(int'(mag % radix), upper));
                mag = mag / radix;
            end
            while (mag != '0);
            foreach (digits[i])
                chars.push_back(digits[i]);
        end
        foreach (chars[i])
        begin
            beat.ch = chars[i];
            beat.last = (i == chars.size() - 1);
            text_expected.push_back(beat);
        end
    endtask

    // drives one request and waits for it to be taken; valid stays high afterwards
    task automatic send_conversion(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            conv_bus.valid <= 1'b0;
            @(posedge clk);
        end
        conv_bus.valid <= 1'b1;
        conv_bus.command <= cmd;
        conv_bus.value <= val;
        @(posedge clk);
        while (!conv_bus.ready)
            @(posedge clk);
        predict_conversion(cmd, val);
    endtask

    task automatic check_char(input logic [CHAR_W-1:0] ch, input logic last);
        text_beat_t want;
        if (text_expected.size() == 0)
        begin
            if (err_count < REPORT_LIMIT)
                $display("unexpected character %02h last %0b with nothing pending", ch, last);
            err_count++;
        end
        else
        begin
            want = text_expected.pop_front();
            if (want.ch !== ch || want.last !== last)
            begin
                if (err_count < REPORT_LIMIT)
                    $display("mismatch: expected char %02h last %0b, got char %02h last %0b",
                             want.ch, want.last, ch, last);
                err_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && text_bus.valid && text_bus.ready)
            check_char(text_bus.out_char, text_bus.last);
        text_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = v >> $urandom_range(63);
            1: v = {32'd0, $urandom} >> $urandom_range(31);
            2: v = {v[63:32], 32'(32'h8000_0000 | $urandom)};
            3: v = 64'($urandom_range(20));
            4:
            begin
                case ($urandom_range(3))
                    0: v = '0;
                    1: v = '1;
                    2: v = {v[63:32], 32'h8000_0000};
                    default: v = {v[63:32], 32'hFFFF_FFFF};
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [CMD_W-1:0] random_command();
        logic [CMD_W-1:0] c;
        if ($urandom_range(99) < 6)
            c = CMD_W'($urandom_range(CMD_RSVD6, CMD_RSVD7));
        else
            c = CMD_W'($urandom_range(K_CHAR, K_PTR));
        return c;
    endfunction

    task automatic test_char_kind();
        send_conversion(K_CHAR, 64'h0);
        send_conversion(K_CHAR, 64'hFF);
        send_conversion(K_CHAR, 64'hFFFF_FFFF_FFFF_FF41);
        send_conversion(K_CHAR, 64'h0000_0000_0000_0100);
    endtask

    task automatic test_decimal_kinds();
        send_conversion(K_SDEC, 64'h0);
        send_conversion(K_SDEC, 64'hFFFF_FFFF);
        send_conversion(K_SDEC, 64'h7FFF_FFFF);
        send_conversion(K_SDEC, 64'hFFFF_FFFF_8000_0000);
        send_conversion(K_SDEC, 64'hA5A5_A5A5_0000_0009);
        send_conversion(K_UDEC, 64'h0);
        send_conversion(K_UDEC, 64'hFFFF_FFFF);
        send_conversion(K_UDEC, 64'h8000_0000);
        send_conversion(K_UDEC, 64'hFFFF_FFFF_0000_000A);
    endtask

    task automatic test_hex_kinds();
        send_conversion(K_HEXL, 64'h0);
        send_conversion(K_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_conversion(K_HEXU, 64'hABCD_EF01);
        send_conversion(K_HEXU, 64'h1234_5678_0000_00FF);
    endtask

    task automatic test_pointer_kind();
        send_conversion(K_PTR, 64'h0);
        send_conversion(K_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_conversion(K_PTR, 64'h1);
        send_conversion(K_PTR, 64'h1_0000_0000);
        send_conversion(CMD_RSVD6, 64'h0);
        send_conversion(CMD_RSVD6, 64'hDEAD_BEEF_0000_0ABC);
        send_conversion(CMD_RSVD7, 64'h0);
        send_conversion(CMD_RSVD7, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_random_conversions(input int count, input int idle_pct,
                                           input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_conversion(random_command(), random_value());
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        conv_bus.valid = 1'b0;
        conv_bus.command = K_CHAR;
        conv_bus.value = '0;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_char_kind();
        test_decimal_kinds();
        test_hex_kinds();
        test_pointer_kind();
        test_random_conversions(RANDOM_PER_PHASE, 0, 0);
        test_random_conversions(RANDOM_PER_PHASE, 73, 0);
        test_random_conversions(RANDOM_PER_PHASE, 0, 73);
        test_random_conversions(RANDOM_PER_PHASE, 34, 34);
        conv_bus.valid <= 1'b0;

        while (text_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
